>>> sv/class_fifo_with_threshold_trigger_unit_defines.svh
// assertion macros shared by the checker
// clocked on i_clk, disabled while i_rst_n is low
`ifndef CLASS_FIFO_WITH_THRESHOLD_TRIGGER_UNIT_DEFINES_SVH
`define CLASS_FIFO_WITH_THRESHOLD_TRIGGER_UNIT_DEFINES_SVH

// same-cycle implication
`define CFTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cftt assertion failed");

// next-cycle implication
`define CFTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cftt assertion failed");

`endif

>>> sv/cftt_pkg.sv
// package for the class fifo with threshold trigger unit
// holds opcodes, field widths, reset constants and the controller/datapath interface types
package cftt_pkg;

    localparam int CFTT_FIFO_DEPTH = 16;

    localparam int OPC_W  = 2;
    localparam int BYTE_W = 8;
    localparam int SMP_W  = 12;
    localparam int CLS_W  = 2;
    localparam int CNT_W  = 16;
    localparam int NUM_CLS = 4;

    localparam logic [SMP_W-1:0] THRESHOLD_RESET = 12'd2048;
    localparam logic [CNT_W-1:0] CNT_MAX         = 16'hFFFF;

    typedef enum logic [OPC_W-1:0] {
        OP_SERIAL = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_MANUAL = 2'd2,
        OP_STOP   = 2'd3
    } t_opcode;

    // controller to datapath
    typedef struct packed {
        logic load;     // latch the incoming request
        logic exec;     // apply the latched request to the state
        logic cfg_we;   // write the threshold register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic halted;
    } t_dp_status;

endpackage

>>> sv/class_fifo_with_threshold_trigger_unit.sv
// a request is latched when accepted, applied to the state in the exec state, then its result is held until taken
// (once stopped the exec state is skipped); no new request is accepted while one is in flight or its result is held,
//   and the head class comes from the registered read of the class store
// reset: synchronous, active low; fifo empty, counters zero, threshold 2048, trigger armed
// the class store has no reset; entries are only used after they are written
module class_fifo_with_threshold_trigger_unit
    import cftt_pkg::*;
#(
    parameter int FIFO_DEPTH = CFTT_FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [OPC_W-1:0]                  i_opcode,
    input  logic [BYTE_W-1:0]                 i_rx_byte,
    input  logic [SMP_W-1:0]                  i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_echo_valid,
    output logic [BYTE_W-1:0]                 o_echo_byte,
    output logic                              o_pop_valid,
    output logic [CLS_W-1:0]                  o_popped_class,
    output logic [CNT_W-1:0]                  o_count_class0,
    output logic [CNT_W-1:0]                  o_count_class1,
    output logic [CNT_W-1:0]                  o_count_class2,
    output logic [CNT_W-1:0]                  o_count_class3,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   o_occupancy,
    output logic                              o_manual_on,
    output logic                              o_stopped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [SMP_W-1:0]                  i_cfg_threshold
);

    t_dp_cmd    cmd;
    t_dp_status status;

    cftt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    cftt_dp #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_cfg_threshold (i_cfg_threshold),
        .i_opcode        (i_opcode),
        .i_rx_byte       (i_rx_byte),
        .i_sample        (i_sample),
        .o_echo_valid    (o_echo_valid),
        .o_echo_byte     (o_echo_byte),
        .o_pop_valid     (o_pop_valid),
        .o_popped_class  (o_popped_class),
        .o_count_class0  (o_count_class0),
        .o_count_class1  (o_count_class1),
        .o_count_class2  (o_count_class2),
        .o_count_class3  (o_count_class3),
        .o_occupancy     (o_occupancy),
        .o_manual_on     (o_manual_on),
        .o_stopped       (o_stopped)
    );

endmodule

>>> sv/cftt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module cftt_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/cftt_ctrl.sv
// controller: takes one request, runs it through the datapath, holds the result
// uses cftt_pkg for the command and status types
module cftt_ctrl
    import cftt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HOLD
    } t_state;

    t_state r_state;
    logic   r_in_stall;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_stall  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_in_stall <= 1'b1;
                        // a halted block only reports its frozen state
                        if (i_status.halted) begin
                            r_state     <= ST_HOLD;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_EXEC: begin
                    r_state     <= ST_HOLD;
                    r_out_valid <= 1'b1;
                end
                ST_HOLD: begin
                    if (!i_out_stall) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_stall  <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = r_in_stall;
    assign o_out_valid  = r_out_valid;
    assign o_cfg_ready  = (r_state == ST_IDLE);
    assign o_cmd.load   = i_in_valid && !r_in_stall;
    assign o_cmd.exec   = (r_state == ST_EXEC);
    assign o_cmd.cfg_we = i_cfg_valid && (r_state == ST_IDLE);

endmodule

>>> sv/cftt_dp.sv
// datapath: class fifo, trigger logic, saturating class counters, mode flags
// uses cftt_pkg and the cftt_ram for the class store
module cftt_dp
    import cftt_pkg::*;
#(
    parameter int FIFO_DEPTH = CFTT_FIFO_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  t_dp_cmd                           i_cmd,
    output t_dp_status                        o_status,
    input  logic [SMP_W-1:0]                  i_cfg_threshold,
    input  logic [OPC_W-1:0]                  i_opcode,
    input  logic [BYTE_W-1:0]                 i_rx_byte,
    input  logic [SMP_W-1:0]                  i_sample,
    output logic                              o_echo_valid,
    output logic [BYTE_W-1:0]                 o_echo_byte,
    output logic                              o_pop_valid,
    output logic [CLS_W-1:0]                  o_popped_class,
    output logic [CNT_W-1:0]                  o_count_class0,
    output logic [CNT_W-1:0]                  o_count_class1,
    output logic [CNT_W-1:0]                  o_count_class2,
    output logic [CNT_W-1:0]                  o_count_class3,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]   o_occupancy,
    output logic                              o_manual_on,
    output logic                              o_stopped
);

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);

    // latched request
    t_opcode             r_opcode;
    logic [BYTE_W-1:0]   r_rx_byte;
    logic [SMP_W-1:0]    r_sample;

    logic [SMP_W-1:0]    r_threshold;
    logic [PTR_W-1:0]    r_head;
    logic [PTR_W-1:0]    r_tail;
    logic [FILL_W-1:0]   r_fill;
    logic [SMP_W-1:0]    r_prev_sample;
    logic                r_armed_off;
    logic [CNT_W-1:0]    r_count [NUM_CLS];
    logic                r_manual;
    logic                r_halt;

    logic                r_echo_valid;
    logic [BYTE_W-1:0]   r_echo_byte;
    logic                r_pop_valid;
    logic [CLS_W-1:0]    r_popped_class;

    logic [CLS_W-1:0]    head_class;
    logic                do_push;
    logic                crossing;
    logic                do_pop;

    // head entry is read every cycle; head only moves during exec
    cftt_ram #(
        .WIDTH (CLS_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_tail),
        .i_wdata (r_rx_byte[CLS_W-1:0]),
        .i_raddr (r_head),
        .o_rdata (head_class)
    );

    assign do_push  = i_cmd.exec && (r_opcode == OP_SERIAL) && !r_manual
                      && (r_fill != FILL_FULL);
    assign crossing = (r_sample > r_threshold) && (r_prev_sample <= r_threshold)
                      && !r_armed_off;
    assign do_pop   = i_cmd.exec && (r_opcode == OP_SAMPLE) && crossing
                      && (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode  <= t_opcode'(i_opcode);
            r_rx_byte <= i_rx_byte;
            r_sample  <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= THRESHOLD_RESET;
            r_head         <= '0;
            r_tail         <= '0;
            r_fill         <= '0;
            r_prev_sample  <= '0;
            r_armed_off    <= 1'b0;
            r_manual       <= 1'b0;
            r_halt         <= 1'b0;
            r_echo_valid   <= 1'b0;
            r_echo_byte    <= '0;
            r_pop_valid    <= 1'b0;
            r_popped_class <= '0;
            for (int k = 0; k < NUM_CLS; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            if (i_cmd.cfg_we) begin
                r_threshold <= i_cfg_threshold;
            end
            // result defaults for a new request
            if (i_cmd.load) begin
                r_echo_valid   <= 1'b0;
                r_echo_byte    <= '0;
                r_pop_valid    <= 1'b0;
                r_popped_class <= '0;
            end
            if (do_push) begin
                r_tail <= (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end
            if (do_pop) begin
                r_head         <= (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                r_fill         <= r_fill - 1'b1;
                r_pop_valid    <= 1'b1;
                r_popped_class <= head_class;
                for (int k = 0; k < NUM_CLS; k++) begin
                    if (head_class == CLS_W'(k) && r_count[k] != CNT_MAX) begin
                        r_count[k] <= r_count[k] + 1'b1;
                    end
                end
            end
            if (i_cmd.exec) begin
                unique case (r_opcode)
                    OP_SERIAL: begin
                        r_echo_valid <= 1'b1;
                        r_echo_byte  <= r_rx_byte;
                    end
                    OP_SAMPLE: begin
                        // disarm on a crossing, re-arm at or below threshold
                        if (r_sample <= r_threshold) begin
                            r_armed_off <= 1'b0;
                        end else if (crossing) begin
                            r_armed_off <= 1'b1;
                        end
                        r_prev_sample <= r_sample;
                    end
                    OP_MANUAL: begin
                        r_manual <= 1'b1;
                    end
                    OP_STOP: begin
                        r_halt <= 1'b1;
                    end
                    default: begin
                        r_halt <= r_halt;
                    end
                endcase
            end
        end
    end

    assign o_status.halted = r_halt;

    assign o_echo_valid   = r_echo_valid;
    assign o_echo_byte    = r_echo_byte;
    assign o_pop_valid    = r_pop_valid;
    assign o_popped_class = r_popped_class;
    assign o_count_class0 = r_count[0];
    assign o_count_class1 = r_count[1];
    assign o_count_class2 = r_count[2];
    assign o_count_class3 = r_count[3];
    assign o_occupancy    = r_fill;
    assign o_manual_on    = r_manual;
    assign o_stopped      = r_halt;

endmodule

>>> sv/cftt_checker.sv
// port-level checker for the class fifo with threshold trigger unit, bound to the top level
// uses cftt_pkg and the macros in class_fifo_with_threshold_trigger_unit_defines.svh
`include "class_fifo_with_threshold_trigger_unit_defines.svh"

module cftt_checker
    import cftt_pkg::*;
#(
    parameter int FIFO_DEPTH = CFTT_FIFO_DEPTH
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic                              o_echo_valid,
    input logic                              o_pop_valid,
    input logic [CLS_W-1:0]                  o_popped_class,
    input logic [$clog2(FIFO_DEPTH+1)-1:0]   o_occupancy,
    input logic                              o_stopped
);

    localparam logic [$clog2(FIFO_DEPTH+1)-1:0] OCC_MAX = ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH);

    // no new request is taken while a result is pending
    `CFTT_ASSERT_NOW(a_stall_while_result, o_out_valid, o_in_stall)
    // one request never both echoes and pops
    `CFTT_ASSERT_NOW(a_echo_pop_exclusive, o_out_valid && o_echo_valid, !o_pop_valid)
    `CFTT_ASSERT_NOW(a_occupancy_bound, 1'b1, o_occupancy <= OCC_MAX)
    // an emergency stop is permanent
    `CFTT_ASSERT_NEXT(a_stop_sticky, o_stopped, o_stopped)
    `CFTT_ASSERT_NEXT(a_result_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_popped_class) && $stable(o_pop_valid))

endmodule

bind class_fifo_with_threshold_trigger_unit cftt_checker #(
    .FIFO_DEPTH (FIFO_DEPTH)
) u_cftt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_echo_valid   (o_echo_valid),
    .o_pop_valid    (o_pop_valid),
    .o_popped_class (o_popped_class),
    .o_occupancy    (o_occupancy),
    .o_stopped      (o_stopped)
);

>>> tb/sv/testbench.sv
// self-checking testbench for class_fifo_with_threshold_trigger_unit
// predicts each result from its own copy of the sorter state; needs cftt_pkg and the unit
module testbench;
    import cftt_pkg::*;

    localparam int OCC_W       = $clog2(CFTT_FIFO_DEPTH + 1);
    localparam int PTR_W       = $clog2(CFTT_FIFO_DEPTH);
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE_CYC  = 4;

    typedef struct packed {
        logic                       echo_valid;
        logic [BYTE_W-1:0]          echo_byte;
        logic                       pop_valid;
        logic [CLS_W-1:0]           popped_class;
        logic [NUM_CLS-1:0][CNT_W-1:0] counts;
        logic [OCC_W-1:0]           occupancy;
        logic                       manual_on;
        logic                       stopped;
    } t_sort_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [OPC_W-1:0]     i_opcode = '0;
    logic [BYTE_W-1:0]    i_rx_byte = '0;
    logic [SMP_W-1:0]     i_sample = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_echo_valid;
    logic [BYTE_W-1:0]    o_echo_byte;
    logic                 o_pop_valid;
    logic [CLS_W-1:0]     o_popped_class;
    logic [CNT_W-1:0]     o_count_class0;
    logic [CNT_W-1:0]     o_count_class1;
    logic [CNT_W-1:0]     o_count_class2;
    logic [CNT_W-1:0]     o_count_class3;
    logic [OCC_W-1:0]     o_occupancy;
    logic                 o_manual_on;
    logic                 o_stopped;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [SMP_W-1:0]     i_cfg_threshold = '0;

    // sorter state as the block should hold it
    logic [CLS_W-1:0]     class_fifo [CFTT_FIFO_DEPTH];
    logic [PTR_W-1:0]     fifo_head = '0;
    logic [PTR_W-1:0]     fifo_tail = '0;
    logic [OCC_W-1:0]     fifo_fill = '0;
    logic [SMP_W-1:0]     last_sample = '0;
    logic                 trig_disarmed = 1'b0;
    logic [CNT_W-1:0]     obj_count [NUM_CLS] = '{default: '0};
    logic                 manual_mode = 1'b0;
    logic                 halted = 1'b0;
    logic [SMP_W-1:0]     thr_model = THRESHOLD_RESET;

    t_sort_result         pending_results [$];
    int                   n_fail = 0;
    int                   idle_cycles = 0;

    // stimulus pacing
    logic [SMP_W-1:0]     thr_now = THRESHOLD_RESET;
    bit                   pace_on = 1'b0;
    bit                   stall_on = 1'b0;
    int                   burst_left = 0;
    int                   stall_hold = 0;
    int                   free_hold = 0;

    class_fifo_with_threshold_trigger_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_rx_byte       (i_rx_byte),
        .i_sample        (i_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_echo_valid    (o_echo_valid),
        .o_echo_byte     (o_echo_byte),
        .o_pop_valid     (o_pop_valid),
        .o_popped_class  (o_popped_class),
        .o_count_class0  (o_count_class0),
        .o_count_class1  (o_count_class1),
        .o_count_class2  (o_count_class2),
        .o_count_class3  (o_count_class3),
        .o_occupancy     (o_occupancy),
        .o_manual_on     (o_manual_on),
        .o_stopped       (o_stopped),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_threshold (i_cfg_threshold)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_sort_result predict_sort(t_opcode op, logic [BYTE_W-1:0] rx,
                                                  logic [SMP_W-1:0] smp);
        t_sort_result r;
        logic [CLS_W-1:0] cls;
        r = '0;
        if (!halted) begin
            case (op)
                OP_SERIAL: begin
                    r.echo_valid = 1'b1;
                    r.echo_byte  = rx;
                    if (!manual_mode && fifo_fill < CFTT_FIFO_DEPTH) begin
                        class_fifo[fifo_tail] = rx[CLS_W-1:0];
                        fifo_tail = fifo_tail + 1'b1;
                        fifo_fill = fifo_fill + 1'b1;
                    end
                end
                OP_SAMPLE: begin
                    // rising crossing while armed
                    if (smp > thr_model && last_sample <= thr_model && !trig_disarmed) begin
                        if (fifo_fill != 0) begin
                            cls = class_fifo[fifo_head];
                            fifo_head = fifo_head + 1'b1;
                            fifo_fill = fifo_fill - 1'b1;
                            r.pop_valid    = 1'b1;
                            r.popped_class = cls;
                            if (obj_count[cls] != CNT_MAX)
                                obj_count[cls] = obj_count[cls] + 1'b1;
                        end
                        trig_disarmed = 1'b1;
                    end
                    if (smp <= thr_model)
                        trig_disarmed = 1'b0;
                    last_sample = smp;
                end
                OP_MANUAL: manual_mode = 1'b1;
                default:   halted = 1'b1;
            endcase
        end
        for (int k = 0; k < NUM_CLS; k++)
            r.counts[k] = obj_count[k];
        r.occupancy = fifo_fill;
        r.manual_on = manual_mode;
        r.stopped   = halted;
        return r;
    endfunction

    always @(posedge i_clk) begin : result_check
        t_sort_result want;
        logic [NUM_CLS-1:0][CNT_W-1:0] got_counts;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                thr_model = i_cfg_threshold;
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(predict_sort(t_opcode'(i_opcode), i_rx_byte, i_sample));
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result arrived with no request pending");
                    n_fail++;
                end else begin
                    want = pending_results.pop_front();
                    got_counts = {o_count_class3, o_count_class2, o_count_class1, o_count_class0};
                    if (o_echo_valid !== want.echo_valid) begin
                        $error("echo_valid: expected %0d, got %0d", want.echo_valid, o_echo_valid);
                        n_fail++;
                    end
                    if (o_echo_byte !== want.echo_byte) begin
                        $error("echo_byte: expected %0h, got %0h", want.echo_byte, o_echo_byte);
                        n_fail++;
                    end
                    if (o_pop_valid !== want.pop_valid) begin
                        $error("pop_valid: expected %0d, got %0d", want.pop_valid, o_pop_valid);
                        n_fail++;
                    end
                    if (o_popped_class !== want.popped_class) begin
                        $error("popped_class: expected %0d, got %0d",
                               want.popped_class, o_popped_class);
                        n_fail++;
                    end
                    for (int k = 0; k < NUM_CLS; k++) begin
                        if (got_counts[k] !== want.counts[k]) begin
                            $error("count_class%0d: expected %0d, got %0d",
                                   k, want.counts[k], got_counts[k]);
                            n_fail++;
                        end
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy, o_occupancy);
                        n_fail++;
                    end
                    if (o_manual_on !== want.manual_on) begin
                        $error("manual_on: expected %0d, got %0d", want.manual_on, o_manual_on);
                        n_fail++;
                    end
                    if (o_stopped !== want.stopped) begin
                        $error("stopped: expected %0d, got %0d", want.stopped, o_stopped);
                        n_fail++;
                    end
                end
            end
        end
    end

    // cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("class_fifo_with_threshold_trigger_unit: mismatch");
                $finish;
            end
        end
    end

    // receiver back-pressure: short stall runs with an occasional long one
    always @(negedge i_clk) begin
        if (!stall_on) begin
            i_out_stall = 1'b0;
        end else if (stall_hold != 0) begin
            i_out_stall = 1'b1;
            stall_hold--;
        end else if (free_hold != 0) begin
            i_out_stall = 1'b0;
            free_hold--;
        end else begin
            i_out_stall = 1'b0;
            stall_hold = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 4);
            free_hold  = $urandom_range(0, 6);
        end
    end

    task automatic send_request(t_opcode op, logic [BYTE_W-1:0] rx, logic [SMP_W-1:0] smp);
        int gap;
        gap = 0;
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap = $urandom_range(1, 8);
            end
            burst_left--;
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_opcode   = op;
        i_rx_byte  = rx;
        i_sample   = smp;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [SMP_W-1:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid     = 1'b1;
        i_cfg_threshold = value;
        thr_now         = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // sample at or below the threshold, often right on it
    function automatic logic [SMP_W-1:0] low_sample();
        if ($urandom_range(0, 3) == 0)
            return thr_now;
        return SMP_W'($urandom_range(0, thr_now));
    endfunction

    // sample above the threshold, often just above it
    function automatic logic [SMP_W-1:0] high_sample();
        if (thr_now == '1)
            return '1;
        if ($urandom_range(0, 3) == 0)
            return thr_now + 1'b1;
        return SMP_W'($urandom_range(thr_now + 1, (1 << SMP_W) - 1));
    endfunction

    // mostly push bursts and clean low/high pairs, with some stray requests
    task automatic run_traffic(int n_req, bit with_manual);
        int sent;
        int kind;
        int reps;
        sent = 0;
        while (sent < n_req) begin
            kind = $urandom_range(0, 9);
            if (kind <= 3) begin
                reps = $urandom_range(1, 5);
                repeat (reps) send_request(OP_SERIAL, BYTE_W'($urandom), SMP_W'($urandom));
                sent += reps;
            end else if (kind <= 7) begin
                reps = $urandom_range(1, 4);
                repeat (reps) begin
                    send_request(OP_SAMPLE, BYTE_W'($urandom), low_sample());
                    send_request(OP_SAMPLE, BYTE_W'($urandom), high_sample());
                end
                sent += 2 * reps;
            end else if (kind == 8) begin
                send_request(OP_SAMPLE, BYTE_W'($urandom), SMP_W'($urandom));
                sent++;
            end else begin
                send_request(t_opcode'($urandom_range(0, with_manual ? 2 : 1)),
                             BYTE_W'($urandom), SMP_W'($urandom));
                sent++;
            end
        end
    endtask

    task automatic test_basic_sorting();
        pace_on  = 1'b1;
        stall_on = 1'b1;
        set_threshold(THRESHOLD_RESET);
        send_request(OP_SERIAL, 8'h00, 12'hFFF);
        send_request(OP_SERIAL, 8'hFF, 12'h000);
        send_request(OP_SERIAL, 8'hA6, 12'h000);
        send_request(OP_SERIAL, 8'h55, 12'h000);
        send_request(OP_SAMPLE, 8'hFF, 12'd2049);   // crossing from the reset sample
        send_request(OP_SAMPLE, 8'h00, 12'd4095);   // still high, no second pop
        send_request(OP_SAMPLE, 8'h00, 12'd2048);   // equal to threshold re-arms
        send_request(OP_SAMPLE, 8'h00, 12'd2049);
        send_request(OP_SAMPLE, 8'h00, 12'd0);
        send_request(OP_SAMPLE, 8'h00, 12'd4095);
        send_request(OP_SAMPLE, 8'h00, 12'd2048);
        send_request(OP_SAMPLE, 8'h00, 12'd2049);
        send_request(OP_SAMPLE, 8'h00, 12'd0);
        send_request(OP_SAMPLE, 8'h00, 12'd3000);   // crossing on an empty fifo
        send_request(OP_SAMPLE, 8'h00, 12'd3500);
        send_request(OP_SAMPLE, 8'h00, 12'd100);
        send_request(OP_SERIAL, 8'h03, 12'd0);
        send_request(OP_SAMPLE, 8'h00, 12'd2049);
    endtask

    task automatic test_threshold_sweep();
        logic [SMP_W-1:0] thr_list [6];
        thr_list = '{12'hFFF, 12'h000, SMP_W'($urandom), 12'h001, 12'hFFE, SMP_W'($urandom)};
        for (int p = 0; p < 6; p++) begin
            set_threshold(thr_list[p]);
            pace_on  = p[0];
            stall_on = (p % 3) != 2;
            run_traffic(90, 1'b0);
        end
    endtask

    // pushes into a full fifo are dropped while each pop frees one slot
    task automatic test_full_fifo();
        pace_on  = 1'b0;
        stall_on = 1'b0;
        set_threshold(SMP_W'($urandom_range(1, (1 << SMP_W) - 2)));
        repeat (CFTT_FIFO_DEPTH + 2)
            send_request(OP_SERIAL, BYTE_W'($urandom), SMP_W'($urandom));
        repeat (4) begin
            send_request(OP_SERIAL, BYTE_W'($urandom) | 8'h03, SMP_W'($urandom));
            send_request(OP_SAMPLE, BYTE_W'($urandom), low_sample());
            send_request(OP_SAMPLE, BYTE_W'($urandom), high_sample());
        end
    endtask

    task automatic test_manual_mode();
        pace_on  = 1'b1;
        stall_on = 1'b1;
        set_threshold(SMP_W'($urandom_range(1, (1 << SMP_W) - 2)));
        send_request(OP_MANUAL, BYTE_W'($urandom), SMP_W'($urandom));
        send_request(OP_SERIAL, 8'h02, SMP_W'($urandom));
        run_traffic(80, 1'b1);
    endtask

    task automatic test_emergency_stop();
        send_request(OP_STOP, BYTE_W'($urandom), SMP_W'($urandom));
        send_request(OP_SERIAL, 8'hFF, 12'hFFF);
        send_request(OP_SAMPLE, 8'h00, 12'd0);
        send_request(OP_SAMPLE, 8'h00, 12'hFFF);
        repeat (40)
            send_request(t_opcode'($urandom_range(0, 3)), BYTE_W'($urandom), SMP_W'($urandom));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_basic_sorting();
        test_threshold_sweep();
        test_full_fifo();
        test_manual_mode();
        test_emergency_stop();
        drain();
        if (n_fail == 0)
            $display("class_fifo_with_threshold_trigger_unit: match");
        else
            $display("class_fifo_with_threshold_trigger_unit: mismatch");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/cftt_pkg.sv
sv/cftt_ram.sv
sv/cftt_ctrl.sv
sv/cftt_dp.sv
sv/class_fifo_with_threshold_trigger_unit.sv
sv/cftt_checker.sv
tb/sv/testbench.sv
